FILE: rtl/tracker_cell_to_xm_packer_defines.svh
// ----------------------------------------------------------------------------
// Tracker cell to XM packer: assertion macros
// Shared property macros for the packer. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TRACKER_CELL_TO_XM_PACKER_DEFINES_SVH
`define TRACKER_CELL_TO_XM_PACKER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the cycle after the antecedent.
`define XMPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The condition must never be seen at a clock edge.
`define XMPK_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define XMPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define XMPK_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/xmpk_pkg.sv
// ----------------------------------------------------------------------------
// XM packer package
// Types and constants shared by the tracker cell to XM packer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xmpk_pkg;

    // Configuration register indexes.
    localparam logic [7:0] CFG_BASE_TRANSPOSE  = 8'd0;
    localparam logic [7:0] CFG_LOWERED_CHANNEL = 8'd1;
    localparam logic [7:0] CFG_CHANNEL_DROP    = 8'd2;
    localparam logic [7:0] CFG_VOLUME_CAP      = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [6:0] RST_BASE_TRANSPOSE  = 7'd24;
    localparam logic [1:0] RST_LOWERED_CHANNEL = 2'd2;
    localparam logic [6:0] RST_CHANNEL_DROP    = 7'd12;
    localparam logic [7:0] RST_VOLUME_CAP      = 8'd80;

    localparam logic [7:0] NO_NOTE   = 8'hFF;
    localparam logic [7:0] MASK_BASE = 8'h80;

    // floor(v * 3 / 5) equals (v * 615) >> 10 for every 8-bit v.
    localparam int          VOL_PROD_W = 18;
    localparam int          VOL_SHIFT  = 10;
    localparam logic [17:0] VOL_RECIP  = 18'd615;

    // Field positions within a packed cell, in mask bit order.
    localparam int FIELD_COUNT = 5;
    localparam logic [2:0] LAST_FULL = 3'd4;

    typedef struct packed {
        logic [6:0] base_transpose;
        logic [1:0] lowered_channel;
        logic [6:0] channel_drop;
        logic [7:0] volume_cap;
    } xmpk_cfg_t;

    // One packed XM cell: bytes in emission order and index of the last one.
    typedef struct packed {
        logic [4:0][7:0] cell_bytes;
        logic [2:0]      last_idx;
    } xmpk_cell_t;

endpackage

FILE: rtl/xmpk_cfg_regs.sv
// ----------------------------------------------------------------------------
// XM packer configuration registers
// Write-only register file holding transpose, lowered channel, channel drop and volume cap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmpk_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output xmpk_pkg::xmpk_cfg_t cfg
);
    import xmpk_pkg::*;

    xmpk_cfg_t cfg_reg;
    xmpk_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Writes to indexes beyond the register list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BASE_TRANSPOSE:  cfg_next.base_transpose  = cfg_data[6:0];
                CFG_LOWERED_CHANNEL: cfg_next.lowered_channel = cfg_data[1:0];
                CFG_CHANNEL_DROP:    cfg_next.channel_drop    = cfg_data[6:0];
                CFG_VOLUME_CAP:      cfg_next.volume_cap      = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_transpose  <= RST_BASE_TRANSPOSE;
            cfg_reg.lowered_channel <= RST_LOWERED_CHANNEL;
            cfg_reg.channel_drop    <= RST_CHANNEL_DROP;
            cfg_reg.volume_cap      <= RST_VOLUME_CAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/xmpk_cell_build.sv
// ----------------------------------------------------------------------------
// XM packer cell builder
// Input register, channel counter and the logic that forms one packed cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmpk_cell_build
#(
    parameter int CHANNEL_COUNT = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 load,
    input  logic [7:0]           note_code,
    input  logic [7:0]           volume_raw,
    input  logic [7:0]           inst_effect,
    input  logic [7:0]           effect_param,
    input  xmpk_pkg::xmpk_cfg_t  cfg,
    output logic                 held,
    output xmpk_pkg::xmpk_cell_t xm_cell
);
    import xmpk_pkg::*;

    localparam logic [1:0] LAST_CHANNEL = 2'(CHANNEL_COUNT - 1);

    logic       held_reg;
    logic       held_next;
    logic [1:0] chan_reg;
    logic [1:0] chan_next;

    logic [7:0] note_reg;
    logic [7:0] vraw_reg;
    logic [7:0] ie_reg;
    logic [7:0] param_reg;
    logic [1:0] item_chan_reg;

    logic [17:0]     vol_prod;
    logic [7:0]      vol_div;
    logic [7:0]      vol;
    logic [7:0]      note_out;
    logic [7:0]      drop;
    logic [4:0]      present;
    logic [4:0][7:0] fld;
    logic [2:0]      idx;

    assign held_next = accept | (held_reg & ~load);
    assign chan_next = (chan_reg == LAST_CHANNEL) ? 2'd0 : chan_reg + 2'd1;
    assign held      = held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            chan_reg <= 2'd0;
        end
        else
        begin
            held_reg <= held_next;
            if (accept)
            begin
                chan_reg <= chan_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            note_reg      <= note_code;
            vraw_reg      <= volume_raw;
            ie_reg        <= inst_effect;
            param_reg     <= effect_param;
            item_chan_reg <= chan_reg;
        end
    end

    always_comb
    begin
        // Volume scaled by three fifths through a reciprocal multiply.
        vol_prod = 18'(vraw_reg) * VOL_RECIP;
        vol_div  = vol_prod[VOL_PROD_W-1:VOL_SHIFT];
        vol      = (vol_div >= cfg.volume_cap) ? cfg.volume_cap : vol_div;

        drop     = (item_chan_reg == cfg.lowered_channel) ? {1'b0, cfg.channel_drop} : 8'd0;
        note_out = note_reg + {1'b0, cfg.base_transpose} - drop;

        fld[0] = note_out;
        fld[1] = {4'h0, ie_reg[3:0]};
        fld[2] = vol;
        fld[3] = {4'h0, ie_reg[7:4]};
        fld[4] = param_reg;

        present[0] = (note_reg != NO_NOTE);
        present[1] = (ie_reg[3:0] != 4'h0);
        present[2] = (vol != 8'd0);
        present[3] = (ie_reg[7:4] != 4'h0);
        present[4] = (param_reg != 8'd0);

        xm_cell = '0;
        idx     = 3'd1;
        if (&present)
        begin
            xm_cell.cell_bytes = fld;
            xm_cell.last_idx   = LAST_FULL;
        end
        else
        begin
            xm_cell.cell_bytes[0] = MASK_BASE | {3'b000, present};
            for (int i = 0; i < FIELD_COUNT; i++)
            begin
                if (present[i])
                begin
                    xm_cell.cell_bytes[idx] = fld[i];
                    idx = idx + 3'd1;
                end
            end
            xm_cell.last_idx = idx - 3'd1;
        end
    end

endmodule

FILE: rtl/xmpk_emit.sv
// ----------------------------------------------------------------------------
// XM packer byte emitter
// Holds one packed cell and shifts its bytes out one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tracker_cell_to_xm_packer_defines.svh"

module xmpk_emit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  xmpk_pkg::xmpk_cell_t xm_cell,
    input  logic                 byte_stall,
    output logic                 byte_valid,
    output logic [7:0]           out_byte,
    output logic                 cell_end,
    output logic                 can_load
);
    import xmpk_pkg::*;

    logic            valid_reg;
    logic [2:0]      left_reg;
    logic [4:0][7:0] bytes_reg;
    logic            take;

    assign byte_valid = valid_reg;
    assign out_byte   = bytes_reg[0];
    assign cell_end   = (left_reg == 3'd0);
    assign take       = valid_reg & ~byte_stall;
    assign can_load   = ~valid_reg | (take & cell_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= 3'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            left_reg  <= xm_cell.last_idx;
        end
        else if (take)
        begin
            if (cell_end)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                left_reg <= left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= xm_cell.cell_bytes;
        end
        else if (take)
        begin
            bytes_reg <= {8'h00, bytes_reg[4:1]};
        end
    end

    `XMPK_ASSERT_NEXT(a_load_shows, clk, rst_n, load, valid_reg, "loaded cell not shown")
    `XMPK_ASSERT_NEXT(a_mid_cell_continues, clk, rst_n, take && !cell_end, valid_reg && (left_reg == $past(left_reg) - 3'd1), "cell cut short")
    `XMPK_ASSERT_NEVER(a_left_in_range, clk, rst_n, valid_reg && (left_reg > LAST_FULL), "byte count out of range")
    `XMPK_ASSERT_NEVER(a_load_only_free, clk, rst_n, load && !can_load, "cell overwritten")

endmodule

FILE: rtl/tracker_cell_to_xm_packer.sv
// ----------------------------------------------------------------------------
// Tracker cell to XM packer
// Turns four-byte tracker cells into XM packed pattern cells, one byte a word.
// ----------------------------------------------------------------------------
// Usage
//   Cell channel: cell_valid/cell_stall carry one tracker cell per word
//   (note_code, volume_raw, inst_effect, effect_param). Byte channel:
//   byte_valid/byte_stall carry one byte of the packed cell per word, with
//   cell_end marking its last byte. Configuration: cfg_valid/cfg_ready with
//   cfg_index and cfg_data; the block is always ready, and writes should
//   only be made while no cell is in flight.
//   A cell is taken into the input register and moves on into the
//   emitter once the output side is free, which then shows its first
//   byte. A cell yields one to five bytes, and the byte channel moves one
//   byte per cycle while byte_stall is low; the next cell moves into the
//   emitter as the cell ahead of it hands over its last byte.
//   A cell is held in an input register while the previous cell drains, so
//   the input is stalled only once that register is full and the emitter
//   is still busy. When byte_stall is high the shown byte holds, and the
//   stall backs up into cell_stall one cell later.
//   Reset clears both stages, the channel counter to the first channel and
//   the registers to transpose 24, lowered channel 2, drop 12, cap 80.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tracker_cell_to_xm_packer
#(
    parameter int CHANNEL_COUNT = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    // Configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    // Tracker cells in
    input  logic       cell_valid,
    output logic       cell_stall,
    input  logic [7:0] note_code,
    input  logic [7:0] volume_raw,
    input  logic [7:0] inst_effect,
    input  logic [7:0] effect_param,
    // Packed bytes out
    output logic       byte_valid,
    input  logic       byte_stall,
    output logic [7:0] out_byte,
    output logic       cell_end
);
    import xmpk_pkg::*;

    xmpk_cfg_t  cfg;
    xmpk_cell_t xm_cell;
    logic       held;
    logic       can_load;
    logic       load;
    logic       accept;

    // A built cell moves into the emitter as soon as the emitter is empty or
    // is handing over the last byte of its current cell.
    assign load       = held & can_load;
    assign cell_stall = held & ~load;
    assign accept     = cell_valid & ~cell_stall;

    xmpk_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    xmpk_cell_build
    #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    )
    u_build
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .load         (load),
        .note_code    (note_code),
        .volume_raw   (volume_raw),
        .inst_effect  (inst_effect),
        .effect_param (effect_param),
        .cfg          (cfg),
        .held         (held),
        .xm_cell      (xm_cell)
    );

    xmpk_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .xm_cell    (xm_cell),
        .byte_stall (byte_stall),
        .byte_valid (byte_valid),
        .out_byte   (out_byte),
        .cell_end   (cell_end),
        .can_load   (can_load)
    );

endmodule

FILE: tb/xm_cell_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XM cell checker
// Watches the register, cell and byte channels of the packer, predicts the
// packed bytes of every accepted cell and compares them in order.
// ----------------------------------------------------------------------------

module xm_cell_checker
#(
    parameter int CHANNEL_COUNT = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       cell_valid,
    input  logic       cell_stall,
    input  logic [7:0] note_code,
    input  logic [7:0] volume_raw,
    input  logic [7:0] inst_effect,
    input  logic [7:0] effect_param,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  logic [7:0] out_byte,
    input  logic       cell_end,
    output int         mismatch_count,
    output int         bytes_outstanding
);
    import xmpk_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } xm_byte_t;

    // Shadow copy of the registers and the channel counter.
    logic [6:0] transpose;
    logic [1:0] low_chan;
    logic [6:0] drop;
    logic [7:0] cap;
    logic [1:0] chan;

    xm_byte_t   packed_byte_q[$];
    xm_byte_t   want;
    xmpk_cell_t next_cell;
    int         fail_tally;

    function automatic xmpk_cell_t pack_xm_cell(input logic [7:0] code,
                                                input logic [7:0] vraw,
                                                input logic [7:0] ie,
                                                input logic [7:0] param);
        xmpk_cell_t xm_cell;
        logic       has_note;
        logic [7:0] note;
        logic [7:0] vol;
        logic [7:0] inst;
        logic [7:0] eff;
        logic [7:0] mask;
        int         scaled;
        int         n;
        xm_cell  = '0;
        has_note = (code != NO_NOTE);
        note     = code + {1'b0, transpose};
        if (chan == low_chan)
        begin
            note = note - {1'b0, drop};
        end
        scaled = (int'(vraw) * 3) / 5;
        vol    = (scaled >= int'(cap)) ? cap : 8'(scaled);
        inst   = {4'h0, ie[3:0]};
        eff    = {4'h0, ie[7:4]};
        n      = 0;
        if (has_note && inst != 0 && vol != 0 && eff != 0 && param != 0)
        begin
            // A full cell goes out as five bare bytes with no mask.
            xm_cell.cell_bytes[0] = note;
            xm_cell.cell_bytes[1] = inst;
            xm_cell.cell_bytes[2] = vol;
            xm_cell.cell_bytes[3] = eff;
            xm_cell.cell_bytes[4] = param;
            n = 5;
        end
        else
        begin
            mask = MASK_BASE | {3'b000, param != 0, eff != 0, vol != 0,
                                inst != 0, has_note};
            xm_cell.cell_bytes[n] = mask;
            n++;
            if (has_note)
            begin
                xm_cell.cell_bytes[n] = note;
                n++;
            end
            if (inst != 0)
            begin
                xm_cell.cell_bytes[n] = inst;
                n++;
            end
            if (vol != 0)
            begin
                xm_cell.cell_bytes[n] = vol;
                n++;
            end
            if (eff != 0)
            begin
                xm_cell.cell_bytes[n] = eff;
                n++;
            end
            if (param != 0)
            begin
                xm_cell.cell_bytes[n] = param;
                n++;
            end
        end
        xm_cell.last_idx = 3'(n - 1);
        return xm_cell;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transpose = RST_BASE_TRANSPOSE;
            low_chan  = RST_LOWERED_CHANNEL;
            drop      = RST_CHANNEL_DROP;
            cap       = RST_VOLUME_CAP;
            chan      = '0;
            packed_byte_q.delete();
            fail_tally = 0;
            mismatch_count    <= 0;
            bytes_outstanding <= 0;
        end
        else
        begin
            // A byte on this edge can only belong to a cell taken earlier.
            if (byte_valid && !byte_stall)
            begin
                if (packed_byte_q.size() == 0)
                begin
                    $display("%0t: unexpected byte: expected none, got %02h end %0b",
                             $time, out_byte, cell_end);
                    fail_tally++;
                end
                else
                begin
                    want = packed_byte_q.pop_front();
                    if (out_byte !== want.value || cell_end !== want.last)
                    begin
                        $display("%0t: byte mismatch: expected %02h end %0b, got %02h end %0b",
                                 $time, want.value, want.last, out_byte, cell_end);
                        fail_tally++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BASE_TRANSPOSE:  transpose = cfg_data[6:0];
                    CFG_LOWERED_CHANNEL: low_chan  = cfg_data[1:0];
                    CFG_CHANNEL_DROP:    drop      = cfg_data[6:0];
                    CFG_VOLUME_CAP:      cap       = cfg_data;
                    default:             ;
                endcase
            end

            if (cell_valid && !cell_stall)
            begin
                next_cell = pack_xm_cell(note_code, volume_raw, inst_effect, effect_param);
                for (int k = 0; k <= int'(next_cell.last_idx); k++)
                begin
                    packed_byte_q.push_back('{value: next_cell.cell_bytes[k],
                                              last: (k == int'(next_cell.last_idx))});
                end
                if (int'(chan) + 1 >= CHANNEL_COUNT)
                begin
                    chan = '0;
                end
                else
                begin
                    chan = chan + 2'd1;
                end
            end

            mismatch_count    <= fail_tally;
            bytes_outstanding <= packed_byte_q.size();
        end
    end

endmodule

FILE: tb/tracker_cell_to_xm_packer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker cell to XM packer test
// Drives tracker cells and register writes into the packer under random
// idling on both channels, while a checker beside the block predicts and
// compares every packed byte; this module gives the verdict.
// ----------------------------------------------------------------------------

module tracker_cell_to_xm_packer_test;

    import xmpk_pkg::*;

    localparam int         CHANNELS     = 4;
    // Any index from here upwards names no register and must be ignored.
    localparam logic [7:0] CFG_BEYOND   = 8'd4;
    // Longest run of cycles without a single word moving before giving up.
    // A correct run never comes close: sender gaps and receiver stalls are
    // short random bursts, and the block moves a byte every free cycle.
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         IDLE_PERCENT = 36;
    localparam int         PHASES       = 6;
    localparam int         PHASE_CELLS  = 44;

    logic       clk        = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;
    logic       cell_valid;
    logic       cell_stall;
    logic [7:0] note_code;
    logic [7:0] volume_raw;
    logic [7:0] inst_effect;
    logic [7:0] effect_param;
    logic       byte_valid;
    logic       byte_stall = 1'b0;
    logic [7:0] out_byte;
    logic       cell_end;

    int         mismatch_count;
    int         bytes_outstanding;
    int         quiet_cycles;

    // Flags captured at the rising edge, so that the stimulus, which runs on
    // the falling edge, knows whether its word was taken without racing the
    // block's own updates.
    logic       cell_taken;
    logic       cfg_taken;

    // When set, neither side idles: this gives a long stretch at full rate.
    logic       calm;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tracker_cell_to_xm_packer #(
        .CHANNEL_COUNT (CHANNELS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .note_code    (note_code),
        .volume_raw   (volume_raw),
        .inst_effect  (inst_effect),
        .effect_param (effect_param),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .out_byte     (out_byte),
        .cell_end     (cell_end)
    );

    xm_cell_checker #(
        .CHANNEL_COUNT (CHANNELS)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cell_valid        (cell_valid),
        .cell_stall        (cell_stall),
        .note_code         (note_code),
        .volume_raw        (volume_raw),
        .inst_effect       (inst_effect),
        .effect_param      (effect_param),
        .byte_valid        (byte_valid),
        .byte_stall        (byte_stall),
        .out_byte          (out_byte),
        .cell_end          (cell_end),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_taken   <= 1'b0;
            cfg_taken    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            cell_taken <= cell_valid && !cell_stall;
            cfg_taken  <= cfg_valid && cfg_ready;
            if ((cell_valid && !cell_stall) || (byte_valid && !byte_stall) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // The receiving side stalls on roughly a third of the cycles, one
    // decision per cycle, so that stalls land on every byte of a cell.
    always @(negedge clk)
    begin
        byte_stall <= rst_n && !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Watchdog: a run that stops moving words is a failure.
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Random idle cycles ahead of a cell. The valid is only lowered when a
    // gap is really taken, so back-to-back cells keep it high throughout.
    task automatic sender_pause();
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            cell_valid = 1'b0;
            @(negedge clk);
        end
    endtask

    // Offers one cell and returns at the falling edge after it was taken.
    task automatic offer_cell(input logic [7:0] code, input logic [7:0] vraw,
                              input logic [7:0] ie, input logic [7:0] param);
        sender_pause();
        note_code    = code;
        volume_raw   = vraw;
        inst_effect  = ie;
        effect_param = param;
        cell_valid   = 1'b1;
        do
        begin
            @(negedge clk);
        end
        while (!cell_taken);
    endtask

    // Random cell content. Each field is absent often enough that every
    // combination of the mask, and the bare five-byte form, turns up.
    task automatic offer_random_cell();
        logic [7:0] code;
        logic [7:0] vraw;
        logic [3:0] inst;
        logic [3:0] eff;
        logic [7:0] param;
        code  = ($urandom_range(0, 99) < 25) ? NO_NOTE : 8'($urandom_range(0, 254));
        vraw  = ($urandom_range(0, 99) < 20) ? 8'd0 : 8'($urandom_range(0, 255));
        inst  = ($urandom_range(0, 99) < 25) ? 4'd0 : 4'($urandom_range(1, 15));
        eff   = ($urandom_range(0, 99) < 25) ? 4'd0 : 4'($urandom_range(1, 15));
        param = ($urandom_range(0, 99) < 25) ? 8'd0 : 8'($urandom_range(1, 255));
        offer_cell(code, vraw, {eff, inst}, param);
    endtask

    // One register write. The valid stays high for a following write; the
    // caller lowers it once the whole batch is in.
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
        begin
            @(negedge clk);
        end
        while (!cfg_taken);
    endtask

    // Every cell yields at least one byte, so once nothing is outstanding
    // the block holds no cell and may safely be reconfigured.
    task automatic wait_drained();
        while (bytes_outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_BASE_TRANSPOSE;
        cfg_data     = 8'd0;
        cell_valid   = 1'b0;
        note_code    = NO_NOTE;
        volume_raw   = 8'd0;
        inst_effect  = 8'd0;
        effect_param = 8'd0;
        calm         = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed cells under the reset settings: transpose 24, channel 2
        // lowered by 12, volume capped at 80. Channels run 0, 1, 2, 3, ...
        offer_cell(NO_NOTE, 8'h00, 8'h00, 8'h00);   // empty cell, mask alone
        offer_cell(8'h30, 8'h80, 8'h35, 8'h44);     // every field, no mask
        offer_cell(NO_NOTE, 8'h00, 8'h50, 8'h12);   // effect and parameter only
        offer_cell(8'h10, 8'hFF, 8'h00, 8'h00);     // volume above the cap
        offer_cell(8'hE7, 8'h00, 8'h00, 8'h00);     // note lands on 0xFF
        offer_cell(8'hF0, 8'h00, 8'h01, 8'h00);     // note wraps past 255
        offer_cell(8'h00, 8'h02, 8'h00, 8'h00);     // lowered channel, volume 1
        offer_cell(8'hFE, 8'h01, 8'h00, 8'h00);     // volume scales to nothing
        offer_cell(NO_NOTE, 8'h00, 8'h0F, 8'h00);   // instrument only
        offer_cell(NO_NOTE, 8'h00, 8'hF0, 8'h00);   // effect only
        offer_cell(NO_NOTE, 8'h00, 8'h00, 8'hFF);   // parameter only
        offer_cell(8'h00, 8'hFF, 8'hFF, 8'hFF);     // note 0, every other field at its top
        offer_cell(NO_NOTE, 8'hFF, 8'hFF, 8'hFF);   // all but the note
        offer_cell(8'h55, 8'hAA, 8'h5A, 8'hA5);
        offer_cell(8'h02, 8'hC8, 8'h00, 8'h80);     // lowered channel again
        offer_cell(8'h7F, 8'h05, 8'h0F, 8'h01);
        cell_valid = 1'b0;
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // The first phase takes every register to its floor, the second
            // to its ceiling with the upper data bits set so that masking is
            // seen; the rest draw full-width random data.
            if (phase == 0)
            begin
                write_reg(CFG_BASE_TRANSPOSE, 8'h00);
                write_reg(CFG_LOWERED_CHANNEL, 8'h00);
                write_reg(CFG_CHANNEL_DROP, 8'h00);
                write_reg(CFG_VOLUME_CAP, 8'h00);
            end
            else if (phase == 1)
            begin
                write_reg(CFG_BASE_TRANSPOSE, 8'hFF);
                write_reg(CFG_LOWERED_CHANNEL, 8'hFF);
                write_reg(CFG_CHANNEL_DROP, 8'hFF);
                write_reg(CFG_VOLUME_CAP, 8'hFF);
            end
            else
            begin
                write_reg(CFG_VOLUME_CAP, 8'($urandom_range(0, 255)));
                write_reg(CFG_CHANNEL_DROP, 8'($urandom_range(0, 255)));
                write_reg(CFG_LOWERED_CHANNEL, 8'($urandom_range(0, 255)));
                write_reg(CFG_BASE_TRANSPOSE, 8'($urandom_range(0, 255)));
            end
            // A write to an index past the register list must change nothing.
            write_reg(8'($urandom_range(CFG_BEYOND, 255)), 8'($urandom_range(0, 255)));
            cfg_valid = 1'b0;

            calm = (phase == 4);
            for (int n = 0; n < PHASE_CELLS; n++)
            begin
                // Midway through one phase the sender holds off until the
                // block has emptied completely, then carries on.
                if (phase == 2 && n == PHASE_CELLS / 2)
                begin
                    cell_valid = 1'b0;
                    wait_drained();
                end
                offer_random_cell();
            end
            cell_valid = 1'b0;
            calm       = 1'b0;
            wait_drained();
        end

        // All cells are in and every byte has been seen; allow the block a
        // few more cycles in case it emits anything unasked for.
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
